/* design/fxalu_pkg.sv */
package fxalu_pkg;

  // Default geometry: Q24.8 on a 32-bit word.
  localparam int DefWordBits     = 32;
  localparam int DefFractionBits = 8;

  // Operation codes carried in the low bits of the input beat.
  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_GT      = 4'd4,
    OP_LT      = 4'd5,
    OP_GE      = 4'd6,
    OP_LE      = 4'd7,
    OP_EQ      = 4'd8,
    OP_NE      = 4'd9,
    OP_MIN     = 4'd10,
    OP_MAX     = 4'd11,
    OP_INC     = 4'd12,
    OP_DEC     = 4'd13,
    OP_TOINT   = 4'd14,
    OP_FROMINT = 4'd15
  } opcode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_t;

endpackage

/* design/fixed_point_q24_8_alu.sv */
// Signed fixed-point ALU on raw WORD_BITS-bit words with FRACTION_BITS fraction
// bits (Q24.8 by default). Each input beat carries an opcode and two operands and
// yields exactly one output beat: add, sub, mul and div (both round half away from zero),
// six compares, min, max, inc, dec, toint and fromint, saturating with an overflow
// or divide-by-zero status. The unit is a fully pipelined stream: it accepts one
// beat every cycle while the output is not stalled, and a new beat can enter before
// earlier ones leave. For Q24.8 as for any geometry, the depth is set by the restoring
// divider, which resolves one quotient bit per pipeline stage; one front stage and two
// round-and-saturate stages surround it. All opcodes pass through every stage, so beats
// leave in order. A stall on the output holds the whole pipeline.
module fixed_point_q24_8_alu #(
  parameter int WORD_BITS     = fxalu_pkg::DefWordBits,
  parameter int FRACTION_BITS = fxalu_pkg::DefFractionBits
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // Fields from bit 0: opcode[4], operand_a[WORD_BITS], operand_b[WORD_BITS], zero fill.
  input  logic [((2*WORD_BITS+4+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // Fields from bit 0: result_value[WORD_BITS], compare_true[1], status[2], zero fill.
  output logic [((WORD_BITS+3+7)/8)*8-1:0]   m_axis_tdata
);
  import fxalu_pkg::*;

  localparam int W       = WORD_BITS;
  localparam int F       = FRACTION_BITS;
  localparam int N       = WORD_BITS + FRACTION_BITS;
  localparam int NDIV    = WORD_BITS + FRACTION_BITS;
  localparam int LAST    = NDIV + 2;
  localparam int TdwOut  = ((WORD_BITS + 3 + 7) / 8) * 8;

  logic                en;
  logic [LAST:0]       valid;

  opcode_t             opcode;
  logic signed [W-1:0] operand_a;
  logic signed [W-1:0] operand_b;

  opcode_t             op_d  [0:NDIV];
  logic [W-1:0]        res_d [0:NDIV];
  status_t             st_d  [0:NDIV];
  logic                cmp_d [0:NDIV];
  logic                neg_d [0:NDIV];
  logic                dz_d  [0:NDIV];
  logic [W-1:0]        rem_d [0:NDIV];
  logic [N-1:0]        num_d [0:NDIV];
  logic [N-1:0]        quo_d [0:NDIV];
  logic [W-1:0]        den_d [0:NDIV];
  logic [2*W-1:0]      prod_d [2:NDIV];
  logic [W-1:0]        mag_a;

  logic [W-1:0]        result_value;
  logic                compare_true;
  status_t             status;

  // Global advance: the pipeline moves when the output register is free or taken.
  assign en            = ~valid[LAST] | m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = valid[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[LAST-1:0], s_axis_tvalid};
    end
  end

  // Unpack the input beat.
  assign opcode    = opcode_t'(s_axis_tdata[3:0]);
  assign operand_a = s_axis_tdata[W+3:4];
  assign operand_b = s_axis_tdata[2*W+3:W+4];

  // Front stage: simple operations, magnitudes and divider setup.
  fxalu_front #(
    .WORD_BITS     (W),
    .FRACTION_BITS (F)
  ) u_front (
    .clk       (clk),
    .en        (en),
    .opcode    (opcode),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .op_q      (op_d[0]),
    .res_q     (res_d[0]),
    .st_q      (st_d[0]),
    .cmp_q     (cmp_d[0]),
    .neg_q     (neg_d[0]),
    .dz_q      (dz_d[0]),
    .mag_a_q   (mag_a),
    .mag_b_q   (den_d[0]),
    .num_q     (num_d[0])
  );

  assign rem_d[0] = '0;
  assign quo_d[0] = '0;

  // Two-stage multiplier on the magnitudes.
  fxalu_mul #(
    .WORD_BITS (W)
  ) u_mul (
    .clk   (clk),
    .en    (en),
    .mag_a (mag_a),
    .mag_b (den_d[0]),
    .prod  (prod_d[2])
  );

  // Divider chain, one quotient bit per stage, with the sideband alongside.
  for (genvar j = 1; j <= NDIV; j++) begin : g_div
    fxalu_div_stage #(
      .WORD_BITS     (W),
      .FRACTION_BITS (F)
    ) u_step (
      .clk     (clk),
      .en      (en),
      .rem_in  (rem_d[j-1]),
      .num_in  (num_d[j-1]),
      .quo_in  (quo_d[j-1]),
      .den_in  (den_d[j-1]),
      .rem_out (rem_d[j]),
      .num_out (num_d[j]),
      .quo_out (quo_d[j]),
      .den_out (den_d[j])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        op_d[j]  <= op_d[j-1];
        res_d[j] <= res_d[j-1];
        st_d[j]  <= st_d[j-1];
        cmp_d[j] <= cmp_d[j-1];
        neg_d[j] <= neg_d[j-1];
        dz_d[j]  <= dz_d[j-1];
      end
    end
  end

  // Delay the product to line up with the divider.
  for (genvar k = 3; k <= NDIV; k++) begin : g_prod
    always_ff @(posedge clk) begin
      if (en) begin
        prod_d[k] <= prod_d[k-1];
      end
    end
  end

  // Rounding, saturation and output register.
  fxalu_pack #(
    .WORD_BITS     (W),
    .FRACTION_BITS (F)
  ) u_pack (
    .clk          (clk),
    .en           (en),
    .op_in        (op_d[NDIV]),
    .neg_in       (neg_d[NDIV]),
    .dz_in        (dz_d[NDIV]),
    .res_in       (res_d[NDIV]),
    .st_in        (st_d[NDIV]),
    .cmp_in       (cmp_d[NDIV]),
    .prod_in      (prod_d[NDIV]),
    .rem_in       (rem_d[NDIV]),
    .quo_in       (quo_d[NDIV]),
    .den_in       (den_d[NDIV]),
    .result_value (result_value),
    .compare_true (compare_true),
    .status       (status)
  );

  assign m_axis_tdata = TdwOut'({status, compare_true, result_value});

endmodule

/* design/fxalu_front.sv */
module fxalu_front #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  fxalu_pkg::opcode_t                    opcode,
  input  logic signed [WORD_BITS-1:0]           operand_a,
  input  logic signed [WORD_BITS-1:0]           operand_b,
  output fxalu_pkg::opcode_t                    op_q,
  output logic        [WORD_BITS-1:0]           res_q,
  output fxalu_pkg::status_t                    st_q,
  output logic                                  cmp_q,
  output logic                                  neg_q,
  output logic                                  dz_q,
  output logic        [WORD_BITS-1:0]           mag_a_q,
  output logic        [WORD_BITS-1:0]           mag_b_q,
  output logic        [WORD_BITS+FRACTION_BITS-1:0] num_q
);
  import fxalu_pkg::*;

  localparam int W = WORD_BITS;
  localparam int F = FRACTION_BITS;
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0] addend;
  logic                do_sub;
  logic        [W:0]   sum;
  logic                lt;
  logic                eq;
  logic                fits;
  logic        [W-1:0] res;
  status_t             st;
  logic                cmp;
  logic        [W-1:0] mag_a;
  logic        [W-1:0] mag_b;

  // One shared sum serves add, subtract, increment and decrement.
  always_comb begin
    addend = (opcode == OP_INC || opcode == OP_DEC) ? W'(1) : operand_b;
    do_sub = (opcode == OP_SUB || opcode == OP_DEC);
    if (do_sub) begin
      sum = {operand_a[W-1], operand_a} - {addend[W-1], addend};
    end else begin
      sum = {operand_a[W-1], operand_a} + {addend[W-1], addend};
    end
  end

  // Signed relations and the range check for the integer conversion.
  assign lt   = operand_a < operand_b;
  assign eq   = operand_a == operand_b;
  assign fits = (&operand_a[W-1:W-F-1]) | ~(|operand_a[W-1:W-F-1]);

  // Magnitudes for the multiplier and the divider.
  assign mag_a = operand_a[W-1] ? W'(-operand_a) : operand_a;
  assign mag_b = operand_b[W-1] ? W'(-operand_b) : operand_b;

  // Results of every operation that needs no multiplier or divider, and of divide by zero.
  always_comb begin
    res = '0;
    st  = ST_OK;
    cmp = 1'b0;
    unique case (opcode) inside
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        if (sum[W] != sum[W-1]) begin
          res = sum[W] ? WMIN : WMAX;
          st  = ST_OVERFLOW;
        end else begin
          res = sum[W-1:0];
        end
      end
      OP_GT:    cmp = !lt && !eq;
      OP_LT:    cmp = lt;
      OP_GE:    cmp = !lt;
      OP_LE:    cmp = lt || eq;
      OP_EQ:    cmp = eq;
      OP_NE:    cmp = !eq;
      OP_MIN:   res = lt ? operand_a : operand_b;
      OP_MAX:   res = (!lt && !eq) ? operand_a : operand_b;
      OP_TOINT: res = operand_a >>> F;
      OP_FROMINT: begin
        if (fits) begin
          res = operand_a << F;
        end else begin
          res = operand_a[W-1] ? WMIN : WMAX;
          st  = ST_OVERFLOW;
        end
      end
      OP_DIV: begin
        if (operand_b == '0) begin
          st = ST_DIV_ZERO;
          if (operand_a == '0) begin
            res = '0;
          end else begin
            res = operand_a[W-1] ? WMIN : WMAX;
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (en) begin
      op_q    <= opcode;
      res_q   <= res;
      st_q    <= st;
      cmp_q   <= cmp;
      neg_q   <= operand_a[W-1] ^ operand_b[W-1];
      dz_q    <= (operand_b == '0);
      mag_a_q <= mag_a;
      mag_b_q <= mag_b;
      num_q   <= {mag_a, {F{1'b0}}};
    end
  end

endmodule

/* design/fxalu_div_stage.sv */
module fxalu_div_stage #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [WORD_BITS-1:0]                  rem_in,
  input  logic [WORD_BITS+FRACTION_BITS-1:0]    num_in,
  input  logic [WORD_BITS+FRACTION_BITS-1:0]    quo_in,
  input  logic [WORD_BITS-1:0]                  den_in,
  output logic [WORD_BITS-1:0]                  rem_out,
  output logic [WORD_BITS+FRACTION_BITS-1:0]    num_out,
  output logic [WORD_BITS+FRACTION_BITS-1:0]    quo_out,
  output logic [WORD_BITS-1:0]                  den_out
);

  localparam int W = WORD_BITS;
  localparam int N = WORD_BITS + FRACTION_BITS;

  logic [W:0]   trial;
  logic         take;
  logic [W:0]   diff;
  logic [W-1:0] rem_next;

  // One restoring step: bring down the next numerator bit and try the divisor.
  always_comb begin
    trial    = {rem_in, num_in[N-1]};
    take     = trial >= {1'b0, den_in};
    diff     = trial - {1'b0, den_in};
    rem_next = take ? diff[W-1:0] : trial[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_next;
      num_out <= {num_in[N-2:0], 1'b0};
      quo_out <= {quo_in[N-2:0], take};
      den_out <= den_in;
    end
  end

endmodule

/* design/fxalu_mul.sv */
module fxalu_mul #(
  parameter int WORD_BITS = 32
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [WORD_BITS-1:0]     mag_a,
  input  logic [WORD_BITS-1:0]     mag_b,
  output logic [2*WORD_BITS-1:0]   prod
);

  localparam int W = WORD_BITS;
  localparam int H = (WORD_BITS + 1) / 2;

  logic [2*H-1:0] xe;
  logic [2*H-1:0] ye;
  logic [2*H-1:0] p00;
  logic [2*H-1:0] p01;
  logic [2*H-1:0] p10;
  logic [2*H-1:0] p11;
  logic [4*H-1:0] total;

  assign xe = (2*H)'(mag_a);
  assign ye = (2*H)'(mag_b);

  // First stage: four half-width partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= xe[H-1:0] * ye[H-1:0];
      p01 <= xe[H-1:0] * ye[2*H-1:H];
      p10 <= xe[2*H-1:H] * ye[H-1:0];
      p11 <= xe[2*H-1:H] * ye[2*H-1:H];
    end
  end

  // Second stage: align and sum the partial products.
  assign total = {p11, p00} + ((4*H)'(p01) << H) + ((4*H)'(p10) << H);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= total[2*W-1:0];
    end
  end

endmodule

/* design/fxalu_pack.sv */
module fxalu_pack #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  fxalu_pkg::opcode_t                    op_in,
  input  logic                                  neg_in,
  input  logic                                  dz_in,
  input  logic [WORD_BITS-1:0]                  res_in,
  input  fxalu_pkg::status_t                    st_in,
  input  logic                                  cmp_in,
  input  logic [2*WORD_BITS-1:0]                prod_in,
  input  logic [WORD_BITS-1:0]                  rem_in,
  input  logic [WORD_BITS+FRACTION_BITS-1:0]    quo_in,
  input  logic [WORD_BITS-1:0]                  den_in,
  output logic [WORD_BITS-1:0]                  result_value,
  output logic                                  compare_true,
  output fxalu_pkg::status_t                    status
);
  import fxalu_pkg::*;

  localparam int W     = WORD_BITS;
  localparam int F     = FRACTION_BITS;
  localparam int MulMw = 2 * W + 1 - F;
  localparam int DivMw = W + F + 1;
  localparam int MW    = (MulMw > DivMw) ? MulMw : DivMw;
  localparam logic [MW-1:0] LIM_NEG = MW'(1) << (W - 1);
  localparam logic [MW-1:0] LIM_POS = LIM_NEG - MW'(1);
  localparam logic [W-1:0]  WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  WMIN = {1'b1, {(W-1){1'b0}}};

  logic [2*W:0]   mul_rnd;
  logic [DivMw-1:0] div_rnd;

  opcode_t        op_r;
  logic           neg_r;
  logic           dz_r;
  logic [W-1:0]   res_r;
  status_t        st_r;
  logic           cmp_r;
  logic [MW-1:0]  mul_mag_r;
  logic [MW-1:0]  div_mag_r;

  logic [MW-1:0]  mag;
  logic           is_neg;
  logic [W-1:0]   res_next;
  status_t        st_next;

  // Round half away from zero on the magnitudes.
  assign mul_rnd = {1'b0, prod_in} + ((2*W+1)'(1) << (F - 1));
  assign div_rnd = {1'b0, quo_in} + DivMw'({rem_in, 1'b0} >= {1'b0, den_in});

  always_ff @(posedge clk) begin
    if (en) begin
      op_r      <= op_in;
      neg_r     <= neg_in;
      dz_r      <= dz_in;
      res_r     <= res_in;
      st_r      <= st_in;
      cmp_r     <= cmp_in;
      mul_mag_r <= MW'(mul_rnd[2*W:F]);
      div_mag_r <= MW'(div_rnd);
    end
  end

  // Apply the sign, saturate, and pick the result for the opcode.
  always_comb begin
    mag      = (op_r == OP_MUL) ? mul_mag_r : div_mag_r;
    is_neg   = neg_r && (mag != '0);
    res_next = res_r;
    st_next  = st_r;
    if (op_r == OP_MUL || (op_r == OP_DIV && !dz_r)) begin
      if (mag > (is_neg ? LIM_NEG : LIM_POS)) begin
        res_next = is_neg ? WMIN : WMAX;
        st_next  = ST_OVERFLOW;
      end else begin
        res_next = is_neg ? W'(-mag[W-1:0]) : mag[W-1:0];
        st_next  = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_value <= res_next;
      compare_true <= cmp_r;
      status       <= st_next;
    end
  end

endmodule

/* sim/fixed_point_q24_8_alu_tb.sv */
`timescale 1ns / 1ps

module fixed_point_q24_8_alu_tb;
  import fxalu_pkg::*;

  localparam int WordBits = 32;
  localparam int FracBits = 8;
  localparam int InBits   = ((2*WordBits+4+7)/8)*8;
  localparam int OutBits  = ((WordBits+3+7)/8)*8;
  localparam int Latency  = WordBits + FracBits + 3;
  localparam int IdleLimit = 5000;
  localparam logic signed [31:0] WMax = 32'sh7fffffff;
  localparam logic signed [31:0] WMin = 32'sh80000000;

  typedef struct packed {
    status_t status;
    logic cmp;
    logic signed [31:0] value;
  } alu_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // Fields from bit 0: opcode, operand_a, operand_b, zero fill.
  logic [InBits-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // Fields from bit 0: result_value, compare_true, status, zero fill.
  logic [OutBits-1:0] m_axis_tdata;

  alu_result_t expected_results[$];
  int errors = 0;
  int idle_cycles = 0;
  bit sink_idling = 1'b1;
  bit sink_hold = 1'b0;
  bit src_idling = 1'b1;

  fixed_point_q24_8_alu dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Saturate a wide signed value into the word, flagging overflow.
  function automatic logic signed [31:0] saturate(input logic signed [127:0] v,
                                                   inout status_t st);
    if (v > 128'sd2147483647) begin
      st = ST_OVERFLOW;
      return WMax;
    end
    if (v < -128'sd2147483648) begin
      st = ST_OVERFLOW;
      return WMin;
    end
    return v[31:0];
  endfunction

  // Divide magnitudes and round half away from zero.
  function automatic logic [127:0] round_div(input logic [127:0] n, input logic [127:0] d);
    logic [127:0] q, r;
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 1;
    return q;
  endfunction

  function automatic alu_result_t alu_predict(input opcode_t op, input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    alu_result_t r;
    status_t st;
    logic signed [127:0] wa, wb, w;
    logic [127:0] ma, mb, m;
    logic neg;
    st = ST_OK;
    r = '0;
    wa = a;
    wb = b;
    ma = wa < 0 ? -wa : wa;
    mb = wb < 0 ? -wb : wb;
    neg = a[31] ^ b[31];
    case (op)
      OP_ADD:   r.value = saturate(wa + wb, st);
      OP_SUB:   r.value = saturate(wa - wb, st);
      OP_MUL: begin
        m = round_div(ma * mb, 128'd1 << FracBits);
        w = neg ? -$signed(m) : $signed(m);
        r.value = saturate(w, st);
      end
      OP_DIV: begin
        if (b == 0) begin
          st = ST_DIV_ZERO;
          r.value = (a == 0) ? 32'sd0 : (a < 0 ? WMin : WMax);
        end else begin
          m = round_div(ma << FracBits, mb);
          w = neg ? -$signed(m) : $signed(m);
          r.value = saturate(w, st);
        end
      end
      OP_GT:    r.cmp = a > b;
      OP_LT:    r.cmp = a < b;
      OP_GE:    r.cmp = a >= b;
      OP_LE:    r.cmp = a <= b;
      OP_EQ:    r.cmp = a == b;
      OP_NE:    r.cmp = a != b;
      OP_MIN:   r.value = a < b ? a : b;
      OP_MAX:   r.value = a > b ? a : b;
      OP_INC:   r.value = saturate(wa + 1, st);
      OP_DEC:   r.value = saturate(wa - 1, st);
      OP_TOINT: r.value = a >>> FracBits;
      default:  r.value = saturate(wa <<< FracBits, st);
    endcase
    r.status = st;
    return r;
  endfunction

  // Send one beat, holding it until the block takes it. Valid stays high
  // afterwards so that beats can follow back to back.
  task automatic send_op(input opcode_t op, input logic signed [31:0] a,
                         input logic signed [31:0] b);
    int gap;
    if (src_idling && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata <= InBits'({b, a, op});
    s_axis_tvalid <= 1'b1;
    expected_results.push_back(alu_predict(op, a, b));
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return WMax - $urandom_range(0, 3);
      1: return WMin + $urandom_range(0, 3);
      2: return $signed($urandom_range(0, 2048)) - 1024;
      3: return 0;
      default: return $urandom;
    endcase
  endfunction

  // Stop offering beats and wait until every expected result has come.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    opcode_t op;
    send_op(OP_ADD, WMax, 32'sd1);
    send_op(OP_SUB, WMin, 32'sd1);
    send_op(OP_MUL, WMax, WMax);
    send_op(OP_MUL, -32'sd384, 32'sd128);
    send_op(OP_MUL, WMin, 32'sd256);
    send_op(OP_DIV, 32'sd256, 32'sd0);
    send_op(OP_DIV, -32'sd5, 32'sd0);
    send_op(OP_DIV, 32'sd0, 32'sd0);
    send_op(OP_DIV, WMin, -32'sd1);
    send_op(OP_DIV, -32'sd256, 32'sd768);
    send_op(OP_INC, WMax, 32'sd0);
    send_op(OP_DEC, WMin, 32'sd0);
    send_op(OP_TOINT, -32'sd1, 32'sd0);
    send_op(OP_FROMINT, 32'sh00800000, 32'sd0);
    send_op(OP_FROMINT, 32'shff7fffff, 32'sd0);
    send_op(OP_MIN, 32'sd7, 32'sd7);
    send_op(OP_MAX, WMin, WMax);
    // Every compare on equal and on unequal operands.
    for (int i = OP_GT; i <= OP_NE; i++) begin
      op = opcode_t'(i);
      send_op(op, 32'sd3, 32'sd3);
      send_op(op, -32'sd2, 32'sd5);
    end
    send_op(OP_GT, WMin, WMax);
    send_op(OP_LT, WMin, WMax);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++)
      send_op(opcode_t'($urandom_range(0, 15)), rand_operand(), rand_operand());
  endtask

  // Receiver holds off while the sender keeps offering beats.
  task automatic test_backpressure();
    sink_hold = 1'b1;
    fork
      begin
        repeat (Latency * 3) @(negedge clk);
        sink_hold = 1'b0;
      end
      test_random(120);
    join
  endtask

  task automatic test_drain_pause();
    wait_drained();
    test_random(40);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(300);
    test_backpressure();
    test_drain_pause();
    test_random(200);
    // Final stretch with no idling on either side.
    src_idling = 1'b0;
    sink_idling = 1'b0;
    test_random(90);
    wait_drained();
    repeat (Latency + 5) @(posedge clk);
    if (errors == 0) $display("fixed_point_q24_8_alu_tb: PASS");
    else $display("fixed_point_q24_8_alu_tb: FAIL");
    $finish;
  end

  // Receiver ready with random stall bursts.
  initial begin
    int stall;
    @(negedge clk);
    forever begin
      if (sink_hold) begin
        m_axis_tready <= 1'b0;
        @(negedge clk);
      end else if (sink_idling && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 11);
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Compare each output beat with the oldest expectation.
  always @(posedge clk) begin
    alu_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[34:0];
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat %h", $time, got);
      end else begin
        want = expected_results.pop_front();
        if (got.value !== want.value) begin
          errors++;
          $display("%0t: value exp %h got %h", $time, want.value, got.value);
        end
        if (got.cmp !== want.cmp) begin
          errors++;
          $display("%0t: compare exp %b got %b", $time, want.cmp, got.cmp);
        end
        if (got.status !== want.status) begin
          errors++;
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted beat on either side.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("fixed_point_q24_8_alu_tb: FAIL");
      $finish;
    end
  end

endmodule
